/* src/pud_pkg.sv */
// Shared types, constants and helper functions for the percent/UTF-8 decoder.
// Used by the front, queue and back modules and by the top level.
// Has no dependencies.
`default_nettype none

package pud_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned NibW  = 4;

  localparam logic [CharW-1:0] MarkerReset = 8'd37;

  // Two entries let the front keep accepting one word per cycle while the
  // back drains the queue at the same rate.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_MARK = 2'd3
  } phase_t;

  typedef struct packed {
    logic             ok;
    logic [NibW-1:0]  val;
  } hex_t;

  // One classified character as it waits between front and back.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_marker;
    logic             hex_ok;
    logic [NibW-1:0]  hex_val;
    logic             eom;
  } entry_t;

  function automatic hex_t hex_decode(input logic [CharW-1:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = NibW'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = NibW'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = NibW'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/pud_if.sv */
// Valid/ready channel interfaces for the decoder's input and result words.
// Depends on pud_pkg for field widths.
`default_nettype none

interface pud_in_if;
  logic                      valid;
  logic                      ready;
  logic [pud_pkg::CharW-1:0] char_in;
  logic                      end_of_message;

  modport source (output valid, output char_in, output end_of_message, input ready);
  modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

interface pud_out_if;
  logic                      valid;
  logic                      ready;
  logic [pud_pkg::UnitW-1:0] code_unit;
  logic                      error;
  logic                      last;

  modport source (output valid, output code_unit, output error, output last, input ready);
  modport sink   (input valid, input code_unit, input error, input last, output ready);
endinterface

`default_nettype wire

/* src/pud_front.sv */
// Front end: holds the marker register, accepts input words and classifies
// each character (marker match, hex digit value). Depends on pud_pkg, pud_if.
`default_nettype none

module pud_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [pud_pkg::CharW-1:0] cfg_wdata,
  pud_in_if.sink                         in_ch,
  input  wire logic                      q_full,
  output      logic                      push,
  output      pud_pkg::entry_t           push_entry
);

  logic [pud_pkg::CharW-1:0] marker_r;
  pud_pkg::hex_t             hex;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= pud_pkg::MarkerReset;
    end else if (cfg_we) begin
      marker_r <= cfg_wdata;
    end
  end

  always_comb begin
    hex                  = pud_pkg::hex_decode(in_ch.char_in);
    in_ch.ready          = !q_full;
    push                 = in_ch.valid && !q_full;
    push_entry.ch        = in_ch.char_in;
    push_entry.is_marker = (in_ch.char_in == marker_r);
    push_entry.hex_ok    = hex.ok;
    push_entry.hex_val   = hex.val;
    push_entry.eom       = in_ch.end_of_message;
  end

endmodule

`default_nettype wire

/* src/pud_queue.sv */
// Short queue of classified characters between the front and the back.
// Depends on pud_pkg for the entry type and depth.
`default_nettype none

module pud_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pud_pkg::entry_t push_entry,
  input  wire logic            pop,
  output      logic            full,
  output      logic            q_valid,
  output      pud_pkg::entry_t head
);

  localparam int unsigned Depth = pud_pkg::QueueDepth;
  localparam int unsigned PtrW  = pud_pkg::QueuePtrW;
  localparam int unsigned CntW  = pud_pkg::QueueCntW;

  pud_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_pop;

  always_comb begin
    full     = (cnt_r == CntW'(Depth));
    q_valid  = (cnt_r != '0);
    head     = mem_r[rptr_r];
    do_pop   = pop && q_valid;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == PtrW'(Depth - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PtrW'(Depth - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CntW'(push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* src/pud_back.sv */
// Back end: runs the escape and UTF-8 assembly state machine on queued
// characters and holds the result word register. Depends on pud_pkg, pud_if.
`default_nettype none

module pud_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire pud_pkg::entry_t head,
  output      logic            pop,
  pud_out_if.source            out_ch
);

  pud_pkg::phase_t             phase_r, phase_nxt;
  logic [pud_pkg::NibW-1:0]    hi_r, hi_nxt;
  logic [pud_pkg::UnitW-1:0]   acc_r, acc_nxt;
  logic [1:0]                  rem_r, rem_nxt;
  logic                        err_r, err_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [pud_pkg::UnitW-1:0]   out_unit_r, out_unit_nxt;
  logic                        out_error_r, out_error_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        take;
  logic                        have;
  logic                        bad_end;
  logic [pud_pkg::UnitW-1:0]   unit;
  logic [pud_pkg::CharW-1:0]   byte_val;

  always_comb begin
    take          = !out_valid_r || out_ch.ready;
    pop           = q_valid && take;
    byte_val      = {hi_r, head.hex_val};

    phase_nxt     = phase_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    err_nxt       = err_r;
    have          = 1'b0;
    unit          = '0;
    bad_end       = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_unit_nxt  = out_unit_r;
    out_error_nxt = out_error_r;
    out_last_nxt  = out_last_r;

    if (pop) begin
      if (!err_r) begin
        case (phase_r)
          pud_pkg::PH_IDLE: begin
            if (head.is_marker) begin
              phase_nxt = pud_pkg::PH_HIGH;
            end else begin
              have = 1'b1;
              unit = {8'h00, head.ch};
            end
          end
          pud_pkg::PH_MARK: begin
            if (head.is_marker) begin
              phase_nxt = pud_pkg::PH_HIGH;
            end else begin
              err_nxt = 1'b1;
            end
          end
          pud_pkg::PH_HIGH: begin
            if (!head.hex_ok) begin
              err_nxt = 1'b1;
            end else begin
              hi_nxt    = head.hex_val;
              phase_nxt = pud_pkg::PH_LOW;
            end
          end
          pud_pkg::PH_LOW: begin
            if (!head.hex_ok) begin
              err_nxt = 1'b1;
            end else if (rem_r != 2'd0) begin
              // A continuation byte must look like 10xxxxxx.
              if (byte_val[7:6] != 2'b10) begin
                err_nxt = 1'b1;
              end else begin
                acc_nxt = {acc_r[9:0], byte_val[5:0]};
                rem_nxt = rem_r - 2'd1;
                if (rem_r == 2'd1) begin
                  have      = 1'b1;
                  unit      = acc_nxt;
                  phase_nxt = pud_pkg::PH_IDLE;
                end else begin
                  phase_nxt = pud_pkg::PH_MARK;
                end
              end
            end else if (!byte_val[7]) begin
              have      = 1'b1;
              unit      = {8'h00, byte_val};
              phase_nxt = pud_pkg::PH_IDLE;
            end else if (byte_val[7:5] == 3'b110) begin
              acc_nxt   = {11'd0, byte_val[4:0]};
              rem_nxt   = 2'd1;
              phase_nxt = pud_pkg::PH_MARK;
            end else if (byte_val[7:4] == 4'b1110) begin
              acc_nxt   = {12'd0, byte_val[3:0]};
              rem_nxt   = 2'd2;
              phase_nxt = pud_pkg::PH_MARK;
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end

      if (head.eom) begin
        // The closing word reports any fault, including an unfinished escape.
        bad_end       = err_nxt || (phase_nxt != pud_pkg::PH_IDLE) || !have;
        out_valid_nxt = 1'b1;
        out_unit_nxt  = bad_end ? '0 : unit;
        out_error_nxt = bad_end;
        out_last_nxt  = 1'b1;
        phase_nxt     = pud_pkg::PH_IDLE;
        hi_nxt        = '0;
        acc_nxt       = '0;
        rem_nxt       = 2'd0;
        err_nxt       = 1'b0;
      end else if (have && !err_nxt) begin
        out_valid_nxt = 1'b1;
        out_unit_nxt  = unit;
        out_error_nxt = 1'b0;
        out_last_nxt  = 1'b0;
      end
    end

    out_ch.valid     = out_valid_r;
    out_ch.code_unit = out_unit_r;
    out_ch.error     = out_error_r;
    out_ch.last      = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pud_pkg::PH_IDLE;
      hi_r        <= '0;
      acc_r       <= '0;
      rem_r       <= 2'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hi_r        <= hi_nxt;
      acc_r       <= acc_nxt;
      rem_r       <= rem_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_unit_r  <= out_unit_nxt;
    out_error_r <= out_error_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

/* src/percent_utf8_decoder_core.sv */
// Path: an accepted word waits in the queue, then the back end registers its
// result word; words that open or continue an escape give none unless they
// end the message. Throughput: one word per cycle while results are not
// stalled, set by the back end's state machine; the two-entry queue absorbs
// result backpressure. Reset: synchronous, active low; the marker returns to
// '%' and all message state, the queue and the result valid flag are cleared.
`default_nettype none

module percent_utf8_decoder_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [pud_pkg::CharW-1:0] cfg_wdata,
  pud_in_if.sink                         in_ch,
  pud_out_if.source                      out_ch
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  pud_pkg::entry_t push_entry;
  pud_pkg::entry_t head;

  pud_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pud_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  pud_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* src/pud_checker.sv */
// Port-level assertions for the decoder core, attached by a bind statement.
// Depends on pud_pkg for widths.
`default_nettype none

module pud_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [pud_pkg::UnitW-1:0] out_code_unit,
  input wire logic                      out_error,
  input wire logic                      out_last
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_code_unit) && $stable(out_error) && $stable(out_last))
    else $error("result payload changed while stalled");

  // An error word always closes the message and carries a zero code unit.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_code_unit == '0))
    else $error("malformed error word");

  // The input only stalls while a result word is waiting downstream.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // Reset leaves no result word on the output.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind percent_utf8_decoder_core pud_checker u_pud_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_code_unit (out_ch.code_unit),
  .out_error     (out_ch.error),
  .out_last      (out_ch.last)
);

`default_nettype wire
